### rtl/wmc_pkg.sv
// Package for the windowed minimum cost block.
// Holds field widths, parameter defaults, register indexes, FSM states and the
// control and status structs shared by the sequencer and the top level.
package wmc_pkg;

  localparam int WMC_WINDOW_DEPTH = 1024;
  localparam int WMC_HOUR_BITS    = 20;

  localparam int COST_W  = 16;
  localparam int NEED_W  = 16;
  localparam int UNIT_W  = 26;
  localparam int OCOST_W = 42;
  localparam int TOTAL_W = 48;
  localparam int KEEP_W  = 10;
  localparam int RATE_W  = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_HOURS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STORAGE_RATE = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRONT_RD,
    ST_FRONT_CHK,
    ST_BACK_RD,
    ST_BACK_MUL,
    ST_BACK_CMP,
    ST_PUSH,
    ST_UNIT_RD,
    ST_UNIT_MUL,
    ST_UNIT_SUM,
    ST_ORDER_MUL,
    ST_OUT
  } wmc_state_t;

  typedef struct packed {
    logic in_fire;
    logic held_zero;
    logic held_one;
    logic full;
    logic front_old;
    logic back_drop;
    logic out_free;
  } wmc_stat_t;

  typedef struct packed {
    logic ready;
    logic rd_front;
    logic rd_back;
    logic front_inc;
    logic back_dec;
    logic push;
    logic mul_en;
    logic mul_sel_unit;
    logic ld_unit;
    logic ld_out;
  } wmc_ctl_t;

endpackage

### rtl/wmc_in_if.sv
// Input channel interface: one hour's cost and order per transaction.
// Depends on wmc_pkg for the field widths.
interface wmc_in_if;
  logic                       valid;
  logic                       ready;
  logic [wmc_pkg::COST_W-1:0] hour_cost;
  logic [wmc_pkg::NEED_W-1:0] order_need;

  modport source (output valid, output hour_cost, output order_need, input ready);
  modport sink (input valid, input hour_cost, input order_need, output ready);
endinterface

### rtl/wmc_out_if.sv
// Result channel interface: unit cost, order cost and running total.
// Depends on wmc_pkg for the field widths.
interface wmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [wmc_pkg::UNIT_W-1:0]  unit_cost;
  logic [wmc_pkg::OCOST_W-1:0] order_cost;
  logic [wmc_pkg::TOTAL_W-1:0] running_total;

  modport source (output valid, output unit_cost, output order_cost,
                  output running_total, input ready);
  modport sink (input valid, input unit_cost, input order_cost,
                input running_total, output ready);
endinterface

### rtl/wmc_cfg_if.sv
// Configuration write channel interface: register index and write data.
// Depends on wmc_pkg for the index and data widths.
interface wmc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wmc_pkg::CFG_IDX_W-1:0]  index;
  logic [wmc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/wmc_mul.sv
// Shared registered multiplier used for storage charges and order costs.
// Standalone; the product register loads only when enabled.
module wmc_mul #(
  parameter int A_W = 26,
  parameter int B_W = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p_r
);

  logic [A_W+B_W-1:0] p_nxt;

  assign p_nxt = (A_W+B_W)'(a) * (A_W+B_W)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

### rtl/wmc_seq.sv
// Sequencer for the windowed minimum cost block.
// Depends on wmc_pkg for the state type and the control and status structs.
module wmc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  wmc_pkg::wmc_stat_t st,
  output wmc_pkg::wmc_ctl_t  ctl
);

  wmc_pkg::wmc_state_t state_r;
  wmc_pkg::wmc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wmc_pkg::ST_IDLE: begin
        if (st.in_fire) begin
          state_nxt = st.held_zero ? wmc_pkg::ST_PUSH : wmc_pkg::ST_FRONT_RD;
        end
      end
      wmc_pkg::ST_FRONT_RD:  state_nxt = wmc_pkg::ST_FRONT_CHK;
      wmc_pkg::ST_FRONT_CHK: begin
        if (!st.front_old) begin
          state_nxt = wmc_pkg::ST_BACK_RD;
        end else begin
          state_nxt = st.held_one ? wmc_pkg::ST_PUSH : wmc_pkg::ST_FRONT_RD;
        end
      end
      wmc_pkg::ST_BACK_RD:   state_nxt = wmc_pkg::ST_BACK_MUL;
      wmc_pkg::ST_BACK_MUL:  state_nxt = wmc_pkg::ST_BACK_CMP;
      wmc_pkg::ST_BACK_CMP: begin
        if (st.back_drop && !st.held_one) begin
          state_nxt = wmc_pkg::ST_BACK_RD;
        end else begin
          state_nxt = wmc_pkg::ST_PUSH;
        end
      end
      wmc_pkg::ST_PUSH:      state_nxt = wmc_pkg::ST_UNIT_RD;
      wmc_pkg::ST_UNIT_RD:   state_nxt = wmc_pkg::ST_UNIT_MUL;
      wmc_pkg::ST_UNIT_MUL:  state_nxt = wmc_pkg::ST_UNIT_SUM;
      wmc_pkg::ST_UNIT_SUM:  state_nxt = wmc_pkg::ST_ORDER_MUL;
      wmc_pkg::ST_ORDER_MUL: state_nxt = wmc_pkg::ST_OUT;
      wmc_pkg::ST_OUT: begin
        if (st.out_free) begin
          state_nxt = wmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      wmc_pkg::ST_IDLE:      ctl.ready = 1'b1;
      wmc_pkg::ST_FRONT_RD:  ctl.rd_front = 1'b1;
      wmc_pkg::ST_FRONT_CHK: ctl.front_inc = st.front_old;
      wmc_pkg::ST_BACK_RD:   ctl.rd_back = 1'b1;
      wmc_pkg::ST_BACK_MUL:  ctl.mul_en = 1'b1;
      wmc_pkg::ST_BACK_CMP:  ctl.back_dec = st.back_drop;
      wmc_pkg::ST_PUSH: begin
        ctl.push      = 1'b1;
        ctl.front_inc = st.full;
      end
      wmc_pkg::ST_UNIT_RD:   ctl.rd_front = 1'b1;
      wmc_pkg::ST_UNIT_MUL:  ctl.mul_en = 1'b1;
      wmc_pkg::ST_UNIT_SUM:  ctl.ld_unit = 1'b1;
      wmc_pkg::ST_ORDER_MUL: begin
        ctl.mul_en       = 1'b1;
        ctl.mul_sel_unit = 1'b1;
      end
      wmc_pkg::ST_OUT:       ctl.ld_out = st.out_free;
      default:               ctl = '0;
    endcase
  end

endmodule

### rtl/windowed_min_cost_with_storage.sv
// The result register loads once the new candidate is pushed and the front candidate is
// read, charged for storage, summed and multiplied by the need. Each front candidate
// checked adds a read and a check step, each back candidate compared a read, multiply
// and compare step. An untaken result holds the block until the output register frees;
// the block is ready for the next input in the cycle after the result loads. Synchronous
// active-low reset clears pointers, hour count, total and configuration, not candidate memory.
module windowed_min_cost_with_storage #(
  parameter int WINDOW_DEPTH = wmc_pkg::WMC_WINDOW_DEPTH,
  parameter int HOUR_BITS    = wmc_pkg::WMC_HOUR_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  wmc_in_if.sink       in_ch,
  wmc_out_if.source    out_ch,
  wmc_cfg_if.sink      cfg_ch
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int PTR_W  = SLOT_W + 1;
  localparam int WORD_W = HOUR_BITS + wmc_pkg::COST_W;
  localparam int MA_W   = (HOUR_BITS > wmc_pkg::UNIT_W) ? HOUR_BITS : wmc_pkg::UNIT_W;
  localparam int P_W    = MA_W + wmc_pkg::RATE_W;
  localparam int DLV_W  = P_W + 1;
  localparam int AGE_CW = (HOUR_BITS > wmc_pkg::KEEP_W) ? HOUR_BITS : wmc_pkg::KEEP_W;

  localparam logic [PTR_W:0]   PTR_MOD  = (PTR_W+1)'(2 * WINDOW_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * WINDOW_DEPTH - 1);
  localparam logic [PTR_W-1:0] DEPTH_P  = PTR_W'(WINDOW_DEPTH);

  localparam longint unsigned HOUR_CAP  = (64'd1 << HOUR_BITS) - 64'd2;
  localparam longint unsigned DEPTH_CAP = longint'(WINDOW_DEPTH) - 1;
  localparam longint unsigned KEEP_CAP  = (HOUR_CAP < DEPTH_CAP) ? HOUR_CAP : DEPTH_CAP;
  localparam longint unsigned KEEP_MAX  = (64'd1 << wmc_pkg::KEEP_W) - 64'd1;
  localparam logic [wmc_pkg::KEEP_W-1:0] KEEP_LIM =
    (KEEP_CAP >= KEEP_MAX) ? wmc_pkg::KEEP_W'(KEEP_MAX) : wmc_pkg::KEEP_W'(KEEP_CAP);

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    q = p - DEPTH_P;
    if (p >= DEPTH_P) begin
      slot_of = q[SLOT_W-1:0];
    end else begin
      slot_of = p[SLOT_W-1:0];
    end
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  wmc_pkg::wmc_stat_t st;
  wmc_pkg::wmc_ctl_t  ctl;

  logic [WORD_W-1:0] cand_mem [WINDOW_DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic [SLOT_W-1:0] rd_addr;
  logic              rd_en;

  logic [PTR_W-1:0] front_r, front_nxt;
  logic [PTR_W-1:0] back_r, back_nxt;
  logic [HOUR_BITS-1:0] hour_r, hour_nxt;
  logic [wmc_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [wmc_pkg::KEEP_W-1:0] keep_r;
  logic [wmc_pkg::RATE_W-1:0] rate_r;
  logic [wmc_pkg::COST_W-1:0] cost_r;
  logic [wmc_pkg::NEED_W-1:0] need_r;
  logic [wmc_pkg::UNIT_W-1:0] unit_r;
  logic out_valid_r, out_valid_nxt;
  logic [wmc_pkg::UNIT_W-1:0]  out_unit_r;
  logic [wmc_pkg::OCOST_W-1:0] out_ocost_r;
  logic [wmc_pkg::TOTAL_W-1:0] out_total_r;

  logic [PTR_W:0]   ptr_diff;
  logic [PTR_W:0]   ptr_wrap;
  logic [PTR_W-1:0] held;
  logic [wmc_pkg::KEEP_W-1:0] keep_eff;
  logic [HOUR_BITS-1:0] rd_hour;
  logic [wmc_pkg::COST_W-1:0] rd_cost;
  logic [HOUR_BITS-1:0] age;
  logic [MA_W-1:0] mul_a;
  logic [wmc_pkg::RATE_W-1:0] mul_b;
  logic [P_W-1:0] mul_p;
  logic [DLV_W-1:0] deliv;
  logic [wmc_pkg::OCOST_W-1:0] ocost;
  logic [wmc_pkg::TOTAL_W:0] total_sum;

  assign ptr_diff = {1'b0, back_r} - {1'b0, front_r};
  assign ptr_wrap = ptr_diff + PTR_MOD;
  assign held     = ptr_diff[PTR_W] ? ptr_wrap[PTR_W-1:0] : ptr_diff[PTR_W-1:0];
  assign keep_eff = (keep_r > KEEP_LIM) ? KEEP_LIM : keep_r;

  assign rd_hour = rdata_r[WORD_W-1:wmc_pkg::COST_W];
  assign rd_cost = rdata_r[wmc_pkg::COST_W-1:0];
  assign age     = hour_r - rd_hour;
  assign deliv   = DLV_W'(rd_cost) + DLV_W'(mul_p);
  assign ocost   = mul_p[wmc_pkg::OCOST_W-1:0];

  assign mul_a = ctl.mul_sel_unit ? MA_W'(unit_r) : MA_W'(age);
  assign mul_b = ctl.mul_sel_unit ? need_r : rate_r;

  assign rd_en   = ctl.rd_front | ctl.rd_back;
  assign rd_addr = ctl.rd_back ? slot_of(ptr_dec(back_r)) : slot_of(front_r);

  assign st.in_fire   = in_ch.valid & in_ch.ready;
  assign st.held_zero = (held == '0);
  assign st.held_one  = (held == PTR_W'(1));
  assign st.full      = (held >= DEPTH_P);
  assign st.front_old = AGE_CW'(age) > AGE_CW'(keep_eff);
  assign st.back_drop = deliv >= DLV_W'(cost_r);
  assign st.out_free  = ~out_valid_r | out_ch.ready;

  wmc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl)
  );

  wmc_mul #(
    .A_W (MA_W),
    .B_W (wmc_pkg::RATE_W)
  ) u_mul (
    .clk (clk),
    .en  (ctl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      cand_mem[slot_of(back_r)] <= {hour_r, cost_r};
    end
    if (rd_en) begin
      rdata_r <= cand_mem[rd_addr];
    end
  end

  always_comb begin
    front_nxt     = ctl.front_inc ? ptr_inc(front_r) : front_r;
    back_nxt      = back_r;
    if (ctl.back_dec) begin
      back_nxt = ptr_dec(back_r);
    end else if (ctl.push) begin
      back_nxt = ptr_inc(back_r);
    end
    total_sum     = {1'b0, total_r} + (wmc_pkg::TOTAL_W+1)'(ocost);
    total_nxt     = total_r;
    hour_nxt      = hour_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    if (ctl.ld_out) begin
      total_nxt     = total_sum[wmc_pkg::TOTAL_W] ? '1 : total_sum[wmc_pkg::TOTAL_W-1:0];
      hour_nxt      = hour_r + 1'b1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      back_r      <= '0;
      hour_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      keep_r      <= '0;
      rate_r      <= '0;
    end else begin
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      hour_r      <= hour_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          wmc_pkg::CFG_KEEP_HOURS:   keep_r <= cfg_ch.data[wmc_pkg::KEEP_W-1:0];
          wmc_pkg::CFG_STORAGE_RATE: rate_r <= cfg_ch.data[wmc_pkg::RATE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st.in_fire) begin
      cost_r <= in_ch.hour_cost;
      need_r <= in_ch.order_need;
    end
    if (ctl.ld_unit) begin
      unit_r <= deliv[wmc_pkg::UNIT_W-1:0];
    end
    if (ctl.ld_out) begin
      out_unit_r  <= unit_r;
      out_ocost_r <= ocost;
      out_total_r <= total_nxt;
    end
  end

  assign in_ch.ready          = ctl.ready;
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.unit_cost     = out_unit_r;
  assign out_ch.order_cost    = out_ocost_r;
  assign out_ch.running_total = out_total_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    st.in_fire |=> !ctl.ready)
    else $error("input accepted while the previous transaction was in progress");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held <= DEPTH_P)
    else $error("candidate count exceeds window depth");

  a_hour_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld_out |=> hour_r == HOUR_BITS'($past(hour_r) + 1'b1))
    else $error("hour count did not advance with the result");

endmodule

### test/wmc_checker.sv
// Checker for the windowed minimum cost block: watches the input, result and
// configuration channels, predicts each hour's result and compares it.
// Depends on wmc_pkg and the three channel interfaces.
module wmc_checker (
  input  logic clk,
  input  logic rst_n,
  wmc_in_if    in_mon,
  wmc_out_if   out_mon,
  wmc_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);

  localparam int WMC_WINDOW_DEPTH = wmc_pkg::WMC_WINDOW_DEPTH;
  localparam int WMC_HOUR_BITS    = wmc_pkg::WMC_HOUR_BITS;
  localparam int COST_W           = wmc_pkg::COST_W;
  localparam int NEED_W           = wmc_pkg::NEED_W;
  localparam int UNIT_W           = wmc_pkg::UNIT_W;
  localparam int OCOST_W          = wmc_pkg::OCOST_W;
  localparam int TOTAL_W          = wmc_pkg::TOTAL_W;
  localparam int KEEP_W           = wmc_pkg::KEEP_W;
  localparam int RATE_W           = wmc_pkg::RATE_W;

  localparam int SLOT_W  = $clog2(WMC_WINDOW_DEPTH);
  localparam int POS_W   = SLOT_W + 1;
  localparam int DELIV_W = COST_W + WMC_HOUR_BITS + RATE_W;

  localparam logic [WMC_HOUR_BITS-1:0] HOUR_CAP =
    WMC_HOUR_BITS'((64'd1 << WMC_HOUR_BITS) - 64'd2);

  typedef struct packed {
    logic [UNIT_W-1:0]  unit_cost;
    logic [OCOST_W-1:0] order_cost;
    logic [TOTAL_W-1:0] running_total;
  } hour_result_t;

  logic [WMC_HOUR_BITS-1:0] cand_hour [WMC_WINDOW_DEPTH];
  logic [COST_W-1:0]        cand_cost [WMC_WINDOW_DEPTH];
  logic [POS_W-1:0]         oldest_pos;
  logic [POS_W-1:0]         next_pos;
  logic [WMC_HOUR_BITS-1:0] hour_count;
  logic [TOTAL_W-1:0]       total_sum;
  logic [KEEP_W-1:0]        keep_reg;
  logic [RATE_W-1:0]        rate_reg;
  hour_result_t             expected_results [$];
  int                       fails = 0;

  function automatic logic [WMC_HOUR_BITS-1:0] cand_age(input logic [POS_W-1:0] pos);
    return hour_count - cand_hour[pos[SLOT_W-1:0]];
  endfunction

  function automatic logic [DELIV_W-1:0] delivered_cost(input logic [POS_W-1:0] pos);
    return DELIV_W'(cand_cost[pos[SLOT_W-1:0]]) + DELIV_W'(cand_age(pos)) * DELIV_W'(rate_reg);
  endfunction

  task automatic predict_hour(input logic [COST_W-1:0] cost, input logic [NEED_W-1:0] need);
    logic [WMC_HOUR_BITS-1:0] keep_lim;
    logic [DELIV_W-1:0]       best;
    logic [TOTAL_W:0]         sum;
    hour_result_t             res;
    keep_lim = WMC_HOUR_BITS'(keep_reg);
    if (keep_lim > WMC_HOUR_BITS'(WMC_WINDOW_DEPTH - 1)) begin
      keep_lim = WMC_HOUR_BITS'(WMC_WINDOW_DEPTH - 1);
    end
    if (keep_lim > HOUR_CAP) begin
      keep_lim = HOUR_CAP;
    end
    while (next_pos != oldest_pos && cand_age(oldest_pos) > keep_lim) begin
      oldest_pos = oldest_pos + 1'b1;
    end
    while (next_pos != oldest_pos && delivered_cost(next_pos - 1'b1) >= DELIV_W'(cost)) begin
      next_pos = next_pos - 1'b1;
    end
    if (POS_W'(next_pos - oldest_pos) >= POS_W'(WMC_WINDOW_DEPTH)) begin
      oldest_pos = oldest_pos + 1'b1;
    end
    cand_hour[next_pos[SLOT_W-1:0]] = hour_count;
    cand_cost[next_pos[SLOT_W-1:0]] = cost;
    next_pos = next_pos + 1'b1;
    best = delivered_cost(oldest_pos);
    res.unit_cost = best[UNIT_W-1:0];
    res.order_cost = OCOST_W'(64'(res.unit_cost) * 64'(need));
    sum = {1'b0, total_sum} + (TOTAL_W + 1)'(res.order_cost);
    total_sum = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    res.running_total = total_sum;
    hour_count = hour_count + 1'b1;
    expected_results.push_back(res);
  endtask

  always @(posedge clk) begin
    hour_result_t got;
    hour_result_t want;
    if (!rst_n) begin
      oldest_pos = '0;
      next_pos = '0;
      hour_count = '0;
      total_sum = '0;
      keep_reg = '0;
      rate_reg = '0;
      expected_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == wmc_pkg::CFG_KEEP_HOURS) begin
          keep_reg = cfg_mon.data[KEEP_W-1:0];
        end else if (cfg_mon.index == wmc_pkg::CFG_STORAGE_RATE) begin
          rate_reg = cfg_mon.data[RATE_W-1:0];
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got.unit_cost = out_mon.unit_cost;
        got.order_cost = out_mon.order_cost;
        got.running_total = out_mon.running_total;
        if (expected_results.size() == 0) begin
          $error("Result transaction with no hour pending: unit_cost %0d", got.unit_cost);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (got.unit_cost !== want.unit_cost) begin
            $error("unit_cost: expected %0d, actual %0d", want.unit_cost, got.unit_cost);
            fails++;
          end
          if (got.order_cost !== want.order_cost) begin
            $error("order_cost: expected %0d, actual %0d", want.order_cost, got.order_cost);
            fails++;
          end
          if (got.running_total !== want.running_total) begin
            $error("running_total: expected %0d, actual %0d",
                   want.running_total, got.running_total);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_hour(in_mon.hour_cost, in_mon.order_need);
      end
    end
    pending <= expected_results.size();
    fail_count <= fails;
  end

endmodule

### test/tb_windowed_min_cost_with_storage.sv
// Top of the windowed minimum cost testbench: clock, reset, stimulus and verdict.
// Depends on wmc_pkg, the channel interfaces, the block and wmc_checker.
module tb_windowed_min_cost_with_storage;

  localparam int COST_W     = wmc_pkg::COST_W;
  localparam int NEED_W     = wmc_pkg::NEED_W;
  localparam int KEEP_W     = wmc_pkg::KEEP_W;
  localparam int RATE_W     = wmc_pkg::RATE_W;
  localparam int CFG_IDX_W  = wmc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = wmc_pkg::CFG_DATA_W;

  typedef enum {PAT_RANDOM, PAT_RISING, PAT_FALLING, PAT_NARROW} cost_pattern_t;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   gap_odds = 0;
  int   stall_odds = 0;
  int   stall_left = 0;
  logic [COST_W-1:0] last_cost = '0;

  wmc_in_if  in_ch ();
  wmc_out_if out_ch ();
  wmc_cfg_if cfg_ch ();

  windowed_min_cost_with_storage i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  wmc_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_hour(input logic [COST_W-1:0] cost, input logic [NEED_W-1:0] need);
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.hour_cost <= cost;
    in_ch.order_need <= need;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [COST_W-1:0] next_cost(input cost_pattern_t pat);
    logic [COST_W:0] tmp;
    case (pat)
      PAT_RISING: begin
        tmp = {1'b0, last_cost} + (COST_W + 1)'($urandom_range(0, 300));
        if (tmp[COST_W]) begin
          tmp = (COST_W + 1)'($urandom_range(0, 1000));
        end
      end
      PAT_FALLING: begin
        if (last_cost < 300) begin
          tmp = (COST_W + 1)'($urandom_range(60000, 65535));
        end else begin
          tmp = {1'b0, last_cost} - (COST_W + 1)'($urandom_range(0, 300));
        end
      end
      PAT_NARROW: begin
        tmp = (COST_W + 1)'($urandom_range(0, 3));
      end
      default: begin
        case ($urandom_range(0, 7))
          0:       tmp = '0;
          1:       tmp = (COST_W + 1)'(16'hFFFF);
          default: tmp = (COST_W + 1)'($urandom_range(0, 65535));
        endcase
      end
    endcase
    last_cost = tmp[COST_W-1:0];
    return last_cost;
  endfunction

  function automatic logic [NEED_W-1:0] pick_need();
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2:       return 16'hFFFF;
      3:       return NEED_W'($urandom_range(1, 4));
      default: return NEED_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [KEEP_W-1:0] keep_val;
    logic [RATE_W-1:0] rate_val;
    cost_pattern_t     pat;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.hour_cost <= '0;
    in_ch.order_need <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: first hours after reset with the reset configuration.
    stall_odds = 4;
    gap_odds = 3;
    send_hour(16'h0000, 16'h0000);
    send_hour(16'hFFFF, 16'hFFFF);
    send_hour(16'hFFFF, 16'h0000);
    send_hour(16'h0000, 16'hFFFF);

    // Longest window without storage charge: rises, ties and drops.
    settle();
    cfg_write(wmc_pkg::CFG_KEEP_HOURS, 16'h03FF);
    cfg_write(wmc_pkg::CFG_STORAGE_RATE, 16'h0000);
    send_hour(16'd10, 16'd1);
    send_hour(16'd20, 16'd1);
    send_hour(16'd20, 16'd1);
    send_hour(16'd5, 16'd3);
    send_hour(16'hFFFF, 16'hFFFF);
    send_hour(16'h0000, 16'hFFFF);

    // Short window with a small charge: the cheap hour ages out.
    settle();
    cfg_write(wmc_pkg::CFG_KEEP_HOURS, 16'd3);
    cfg_write(wmc_pkg::CFG_STORAGE_RATE, 16'd1);
    send_hour(16'd0, 16'd1);
    repeat (5) send_hour(16'd100, 16'd1);

    // The window is shortened while candidates are held.
    settle();
    cfg_write(wmc_pkg::CFG_KEEP_HOURS, 16'd1);
    send_hour(16'd200, 16'd1);
    send_hour(16'd200, 16'd1);

    // Largest charge and window.
    settle();
    cfg_write(wmc_pkg::CFG_KEEP_HOURS, 16'hFFFF);
    cfg_write(wmc_pkg::CFG_STORAGE_RATE, 16'hFFFF);
    send_hour(16'hFFFF, 16'hFFFF);
    send_hour(16'hFFFF, 16'hFFFF);
    send_hour(16'd0, 16'd1);

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case ($urandom_range(0, 4))
        0:       keep_val = '0;
        1:       keep_val = KEEP_W'(1);
        2:       keep_val = '1;
        3:       keep_val = KEEP_W'($urandom_range(2, 40));
        default: keep_val = KEEP_W'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 4))
        0:       rate_val = '0;
        1:       rate_val = RATE_W'(1);
        2:       rate_val = '1;
        3:       rate_val = RATE_W'($urandom_range(0, 300));
        default: rate_val = RATE_W'($urandom_range(0, 65535));
      endcase
      pat = cost_pattern_t'($urandom_range(0, 3));
      if (phase == 0) begin
        keep_val = '1;
        rate_val = '0;
        pat = PAT_RISING;
      end else if (phase == 1) begin
        keep_val = '1;
        rate_val = '1;
        pat = PAT_RANDOM;
      end
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(CFG_IDX_W'($urandom_range(2, 255)),
                  CFG_DATA_W'($urandom_range(0, 65535)));
      end
      cfg_write(wmc_pkg::CFG_KEEP_HOURS,
                {CFG_DATA_W'($urandom_range(0, 63)) << KEEP_W} | CFG_DATA_W'(keep_val));
      cfg_write(wmc_pkg::CFG_STORAGE_RATE, rate_val);
      if (phase >= 6) begin
        gap_odds = 0;
        stall_odds = 0;
      end else begin
        gap_odds = $urandom_range(2, 6);
        stall_odds = $urandom_range(2, 6);
      end
      for (int n = 0; n < 125; n++) begin
        if (n == 60) begin
          drain();
        end
        send_hour(next_cost(pat), pick_need());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
